@@ rtl/lru_key_value_cache_unit_assert.svh @@
// Assertion macros for the checker file of the cache unit.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define LKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LKVC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  localparam int ACTIVE_ENTRIES_W = 5;
  localparam logic [ACTIVE_ENTRIES_W-1:0] ACTIVE_ENTRIES_RST = 5'd16;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 1;
  localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_ENTRIES = 1'b0;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_UPDATE
  } lkvc_state_t;

  typedef struct packed {
    logic load_req;
    logic capture;
    logic scan_step;
    logic update;
    logic load_out;
  } lkvc_cmd_t;

  typedef struct packed {
    logic put;
    logic hit;
    logic empty;
    logic scan_done;
  } lkvc_status_t;

endpackage

`default_nettype wire

@@ rtl/lkvc_if.sv @@
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

@@ rtl/lkvc_ram.sv @@
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_W-1:0]    waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_W-1:0]    raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/lkvc_ctrl.sv @@
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire lkvc_status_t status,
  output lkvc_cmd_t         cmd
);
  lkvc_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.capture = 1'b1;
        if (status.put && !status.hit && !status.empty) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_UPDATE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_UPDATE: begin
        // A get waits here until the result register is free.
        if (status.put || !out_valid || out_ready) begin
          cmd.update   = 1'b1;
          cmd.load_out = !status.put;
          in_ready     = 1'b1;
          state_next   = in_valid ? ST_MATCH : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.load_req   = in_valid && in_ready;
    out_valid_next = cmd.load_out || (out_valid && !out_ready);
  end

endmodule

`default_nettype wire

@@ rtl/lkvc_dp.sv @@
`default_nettype none

module lkvc_dp import lkvc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lkvc_cmd_t                   cmd,
  output lkvc_status_t                     status,
  input  wire logic [ACTIVE_ENTRIES_W-1:0] active_entries,
  input  wire logic                        in_req_type,
  input  wire logic [KEY_BITS-1:0]         in_key,
  input  wire logic [VALUE_BITS-1:0]       in_value,
  output logic                             out_hit,
  output logic      [VALUE_BITS-1:0]       out_read_value
);
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  logic                  req_put;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic [ENTRIES-1:0]    slot_valid;
  logic [KEY_BITS-1:0]   slot_key  [ENTRIES];
  logic [RANK_W-1:0]     slot_rank [ENTRIES];

  logic                  hit_r;
  logic                  fill_r;
  logic [IDX_W-1:0]      tgt_idx;
  logic [RANK_W-1:0]     tgt_rank;
  logic [CNT_W-1:0]      scan_cnt;

  logic [CNT_W-1:0]      active_n;
  logic [ENTRIES-1:0]    active_vec;
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    empty_vec;
  logic                  hit_any;
  logic                  empty_any;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      empty_idx;
  logic [RANK_W-1:0]     hit_rank;
  logic [RANK_W-1:0]     scan_rank;
  logic                  scan_done;
  logic                  do_change;
  logic [VALUE_BITS-1:0] ram_rdata;

  // Capacity of zero acts as one; capacity saturates at the slot count.
  always_comb begin
    if (active_entries == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(active_entries) > 32'(ENTRIES)) begin
      active_n = CNT_W'(ENTRIES);
    end else begin
      active_n = CNT_W'(active_entries);
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cmp
    assign active_vec[i] = CNT_W'(i) < active_n;
    assign match_vec[i]  = active_vec[i] && slot_valid[i] && (slot_key[i] == req_key);
    assign empty_vec[i]  = active_vec[i] && !slot_valid[i];
  end

  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (empty_vec[i]) begin
        empty_any = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign hit_rank  = slot_rank[hit_idx];
  assign scan_rank = slot_rank[scan_cnt[IDX_W-1:0]];
  assign scan_done = scan_cnt >= active_n;
  assign do_change = req_put || hit_r;

  assign status.put       = req_put;
  assign status.hit       = hit_any;
  assign status.empty     = empty_any;
  assign status.scan_done = scan_done;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_put   <= (in_req_type == REQ_PUT);
      req_key   <= in_key;
      req_value <= in_value;
    end
    if (cmd.capture) begin
      hit_r    <= hit_any;
      fill_r   <= !hit_any && empty_any;
      tgt_idx  <= hit_any ? hit_idx : (empty_any ? empty_idx : '0);
      tgt_rank <= hit_any ? hit_rank : slot_rank[0];
      scan_cnt <= CNT_W'(1);
    end else if (cmd.scan_step) begin
      // Strictly greater keeps the lowest index on a tie.
      if (scan_rank > tgt_rank) begin
        tgt_rank <= scan_rank;
        tgt_idx  <= scan_cnt[IDX_W-1:0];
      end
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_hit        <= hit_r;
      out_read_value <= hit_r ? ram_rdata : '0;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (rst) begin
        slot_valid[i] <= 1'b0;
        slot_rank[i]  <= '0;
      end else if (cmd.update && do_change) begin
        if (tgt_idx == IDX_W'(i)) begin
          slot_rank[i] <= '0;
          if (fill_r) begin
            slot_valid[i] <= 1'b1;
          end
        end else if (slot_valid[i] && (fill_r || slot_rank[i] < tgt_rank)) begin
          slot_rank[i] <= slot_rank[i] + RANK_W'(1);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.update && req_put && tgt_idx == IDX_W'(i)) begin
        slot_key[i] <= req_key;
      end
    end
  end

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (cmd.update && req_put),
    .waddr (tgt_idx),
    .wdata (req_value),
    .re    (cmd.capture),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache_unit.sv @@
// Channel  Dir  Payload                     Transfer
// req      in   req_type, key, value        valid & ready
// rsp      out  hit, read_value             valid & ready
// apb      in   active_entries at addr 0    psel & penable & pwrite
//
// A get, a put that hits and a put that fills an empty slot pass through a
// parallel key compare in the match state, then a write of ranks, keys and
// data in the update state. A put that evicts runs a rank scan between the
// two that finds the least recent slot, one rank register per cycle.
// Reset clears all valid bits and ranks at once and sets capacity to 16.
// A get result waits in the output register; the next get holds in its
// update cycle until that result has been taken.
`default_nettype none

module lru_key_value_cache_unit import lkvc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lkvc_req_if.sink                   req,
  lkvc_rsp_if.source                 rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);
  logic [ACTIVE_ENTRIES_W-1:0] active_entries;
  lkvc_cmd_t                   cmd;
  lkvc_status_t                status;
  logic                        in_ready;
  logic                        out_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_ENTRIES_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_ENTRIES) begin
      active_entries <= pwdata[ACTIVE_ENTRIES_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_ACTIVE_ENTRIES) ? APB_DATA_W'(active_entries) : '0;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .active_entries (active_entries),
    .in_req_type    (req.req_type),
    .in_key         (req.key),
    .in_value       (req.value),
    .out_hit        (rsp.hit),
    .out_read_value (rsp.read_value)
  );

endmodule

`default_nettype wire

@@ rtl/lkvc_checker.sv @@
`default_nettype none

`include "lru_key_value_cache_unit_assert.svh"

module lkvc_checker import lkvc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_hit,
  input wire logic [VALUE_BITS-1:0] out_read_value
);

  `LKVC_ASSERT(a_rsp_hold, out_valid && !out_ready |=> out_valid, "Result dropped while stalled.")
  `LKVC_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_read_value == '0, "Miss with nonzero value.")
  `LKVC_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "Item accepted while busy.")
  `LKVC_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "Result present after reset.")

endmodule

bind lru_key_value_cache_unit lkvc_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .out_hit        (rsp.hit),
  .out_read_value (rsp.read_value)
);

`default_nettype wire

@@ tb/lru_key_value_cache_unit_tb.sv @@
module lru_key_value_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int KEY_POOL       = 24;
  localparam int N_PHASES       = 10;
  localparam int ITEMS_PER_PASS = 40;
  localparam int STEADY_PHASE   = 7;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 2 * ENTRIES_DEF + 8;
  localparam int STALL_LIMIT    = 3000;

  typedef struct packed {
    logic                      hit;
    logic [VALUE_BITS_DEF-1:0] read_value;
  } lookup_result_t;

  class lru_cache_predictor;
    logic [ACTIVE_ENTRIES_W-1:0] capacity_reg;
    bit                          slot_used[ENTRIES_DEF];
    logic [KEY_BITS_DEF-1:0]     slot_tag[ENTRIES_DEF];
    logic [VALUE_BITS_DEF-1:0]   slot_val[ENTRIES_DEF];
    logic [3:0]                  slot_rank[ENTRIES_DEF];
    lookup_result_t              lookups_due[$];
    int                          mismatches;
    int                          n_gets;
    int                          n_hits;
    int                          n_puts;
    int                          n_evictions;

    function new();
      capacity_reg = ACTIVE_ENTRIES_RST;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_tag[i]  = '0;
        slot_val[i]  = '0;
        slot_rank[i] = '0;
      end
      mismatches  = 0;
      n_gets      = 0;
      n_hits      = 0;
      n_puts      = 0;
      n_evictions = 0;
    endfunction

    function void set_capacity(logic [APB_DATA_W-1:0] word);
      capacity_reg = word[ACTIVE_ENTRIES_W-1:0];
    endfunction

    function int live_slots();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > ENTRIES_DEF) return ENTRIES_DEF;
      return int'(capacity_reg);
    endfunction

    function void promote(int s);
      logic [3:0] old;
      old = slot_rank[s];
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (i != s && slot_used[i] && slot_rank[i] < old) slot_rank[i]++;
      end
      slot_rank[s] = '0;
    endfunction

    function void note_request(logic kind, logic [KEY_BITS_DEF-1:0] k,
                               logic [VALUE_BITS_DEF-1:0] v);
      int             n;
      int             found;
      int             victim;
      lookup_result_t r;
      n     = live_slots();
      found = -1;
      for (int i = 0; i < n; i++) begin
        if (found < 0 && slot_used[i] && slot_tag[i] == k) found = i;
      end
      if (kind == REQ_GET) begin
        n_gets++;
        if (found >= 0) begin
          n_hits++;
          promote(found);
          r.hit        = 1'b1;
          r.read_value = slot_val[found];
        end else begin
          r.hit        = 1'b0;
          r.read_value = '0;
        end
        lookups_due.push_back(r);
        return;
      end
      n_puts++;
      if (found >= 0) begin
        slot_val[found] = v;
        promote(found);
        return;
      end
      for (int i = 0; i < n; i++) begin
        if (!slot_used[i]) begin
          slot_tag[i] = k;
          slot_val[i] = v;
          for (int j = 0; j < ENTRIES_DEF; j++) begin
            if (slot_used[j]) slot_rank[j]++;
          end
          slot_used[i] = 1'b1;
          slot_rank[i] = '0;
          return;
        end
      end
      victim = 0;
      for (int i = 1; i < n; i++) begin
        if (slot_rank[i] > slot_rank[victim]) victim = i;
      end
      n_evictions++;
      slot_tag[victim] = k;
      slot_val[victim] = v;
      promote(victim);
    endfunction

    function void check_result(logic hit, logic [VALUE_BITS_DEF-1:0] rv);
      lookup_result_t want;
      if (lookups_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, hit=%0b read_value=%h", $time, hit, rv);
        return;
      end
      want = lookups_due.pop_front();
      if (want.hit !== hit) begin
        mismatches++;
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
      end
      if (want.read_value !== rv) begin
        mismatches++;
        $display("%0t: read_value expected %h actual %h", $time, want.read_value, rv);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lru_cache_predictor      cache_sb = new();
  logic [KEY_BITS_DEF-1:0] key_pool[KEY_POOL];
  bit                      no_gaps = 1'b0;
  bit                      hold_rsp = 1'b0;
  int                      idle_cycles = 0;
  int                      config_writes = 0;
  int                      capacity_plan[N_PHASES] = '{16, 2, 0, 1, 31, 17, 5, 16, 3, 12};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 28);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      cache_sb.check_result(rsp_ch.hit, rsp_ch.read_value);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [KEY_BITS_DEF-1:0] k,
                           logic [VALUE_BITS_DEF-1:0] v);
    while (!no_gaps && $urandom_range(0, 99) < 28) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.key      <= k;
    req_ch.value    <= v;
    do @(posedge clk); while (!req_ch.ready);
    cache_sb.note_request(kind, k, v);
  endtask

  task automatic send_random();
    logic                    kind;
    logic [KEY_BITS_DEF-1:0] k;
    kind = ($urandom_range(0, 1) == 0) ? REQ_GET : REQ_PUT;
    if ($urandom_range(0, 99) < 85) begin
      k = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      k = KEY_BITS_DEF'($urandom());
    end
    send_item(kind, k, VALUE_BITS_DEF'($urandom()));
  endtask

  task automatic write_capacity(int cap);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[ACTIVE_ENTRIES_W-1:0] = ACTIVE_ENTRIES_W'(cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_ENTRIES;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cache_sb.set_capacity(word);
    config_writes++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (cache_sb.lookups_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_GET;
    req_ch.key      <= '0;
    req_ch.value    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= ADDR_ACTIVE_ENTRIES;
    pwdata          <= '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_BITS_DEF'($urandom());
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(REQ_GET, 16'h0000, 16'h0000);
    send_item(REQ_PUT, 16'h0000, 16'hFFFF);
    send_item(REQ_PUT, 16'hFFFF, 16'h0000);
    send_item(REQ_GET, 16'hFFFF, 16'hFFFF);
    send_item(REQ_GET, 16'h0000, 16'h0000);
    send_item(REQ_PUT, 16'h0000, 16'h5A5A);
    send_item(REQ_GET, 16'h0000, 16'h0000);
    send_item(REQ_GET, 16'h1234, 16'h0000);
    send_item(REQ_PUT, 16'hA5A5, 16'h8001);
    send_item(REQ_GET, 16'hA5A5, 16'h0000);
    send_item(REQ_PUT, 16'hFFFF, 16'h7FFE);
    send_item(REQ_GET, 16'hFFFF, 16'h0000);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_capacity(capacity_plan[p]);
      end
      no_gaps = (p == STEADY_PHASE);
      if (p == PRESSURE_PHASE) hold_rsp = 1'b1;
      repeat (ITEMS_PER_PASS) send_random();
    end
    drain();

    $display("Covered %0d gets (%0d hits) and %0d puts with %0d evictions,",
             cache_sb.n_gets, cache_sb.n_hits, cache_sb.n_puts, cache_sb.n_evictions);
    $display("across %0d capacity writes including 0, 1, 16, 17 and 31.", config_writes);
    if (cache_sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
